FILE: src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Widths, codes and controller/datapath interface types shared by the LWE
// bit decryption block.
// ----------------------------------------------------------------------------
package lbd_pkg;

  localparam int VAL_W      = 31;
  localparam int IDX_W      = 10;
  localparam int ACT_W      = 2;
  localparam int STEP_CNT_W = 5;
  localparam int PADDR_W    = 3;

  localparam logic [VAL_W-1:0]      MOD_RESET = 31'd2147483629;
  localparam logic [VAL_W-1:0]      MOD_MIN   = 31'd3;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(VAL_W - 1);

  // register index as seen in paddr[2]
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ELEM  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    MM_RED_V  = 2'd0,
    MM_RED_S  = 2'd1,
    MM_MUL    = 2'd2,
    MM_RED_IP = 2'd3
  } mm_op_t;

  typedef struct packed {
    logic   ld_item;
    logic   mem_rd;
    logic   mem_wr;
    logic   mm_start;
    mm_op_t mm_op;
    logic   ip_acc;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    act_t action;
    logic idx_ok;
    logic mm_done;
  } dp_stat_t;

endpackage

FILE: src/lbd_modmul.sv
// ----------------------------------------------------------------------------
// lbd_modmul
// Bit-serial modular multiplier: res = (a * x) mod q, one bit of x per cycle,
// MSB first. With a = 1 it reduces x mod q. Requires a < q.
// ----------------------------------------------------------------------------
module lbd_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lbd_pkg::VAL_W-1:0] x,
  input  logic [lbd_pkg::VAL_W-1:0] a,
  input  logic [lbd_pkg::VAL_W-1:0] q,
  output logic                      done,
  output logic [lbd_pkg::VAL_W-1:0] res
);
  import lbd_pkg::*;

  logic [VAL_W-1:0]      acc_r, acc_nxt;
  logic [VAL_W-1:0]      x_r;
  logic [VAL_W-1:0]      a_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  run_r;
  logic                  done_r;

  logic [VAL_W+1:0] t;
  logic [VAL_W+1:0] q1;
  logic [VAL_W+1:0] q2;

  // acc < q, so 2*acc + a < 3q: at most two subtractions of q
  always_comb begin
    q1 = {2'b00, q};
    q2 = {1'b0, q, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (x_r[VAL_W-1] ? {2'b00, a_r} : '0);
    if (t >= q2) begin
      acc_nxt = VAL_W'(t - q2);
    end else if (t >= q1) begin
      acc_nxt = VAL_W'(t - q1);
    end else begin
      acc_nxt = VAL_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      a_r   <= a;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      x_r   <= {x_r[VAL_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

FILE: src/lbd_datapath.sv
// ----------------------------------------------------------------------------
// lbd_datapath
// Request registers, secret store, shared modular multiplier, inner product
// accumulator and result register.
// ----------------------------------------------------------------------------
module lbd_datapath #(
  parameter int DIM = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lbd_pkg::dp_cmd_t          cmd,
  output lbd_pkg::dp_stat_t         stat,
  input  logic [lbd_pkg::VAL_W-1:0] q,
  input  logic [lbd_pkg::ACT_W-1:0] in_action,
  input  logic [lbd_pkg::IDX_W-1:0] in_index,
  input  logic [lbd_pkg::VAL_W-1:0] in_value,
  output logic                      out_recovered_bit,
  output logic [lbd_pkg::VAL_W-1:0] out_difference
);
  import lbd_pkg::*;

  localparam int AW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CMPW = 13;

  act_t             act_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;

  logic [VAL_W-1:0] mem [DIM];
  logic [VAL_W-1:0] mem_q_r;

  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       addr;

  mm_op_t           dest_r;
  logic [VAL_W-1:0] vred_r;
  logic [VAL_W-1:0] prod_r;
  logic [VAL_W-1:0] ipred_r;
  logic [VAL_W-1:0] ip_r;

  logic [VAL_W-1:0] mm_x;
  logic [VAL_W-1:0] mm_a;
  logic             mm_done;
  logic [VAL_W-1:0] mm_res;

  logic [VAL_W:0]   ip_sum;
  logic [VAL_W-1:0] ip_nxt;
  logic [VAL_W:0]   diff_w;
  logic [VAL_W-1:0] diff;
  logic [VAL_W-1:0] lo;
  logic [VAL_W+1:0] three_q;
  logic [VAL_W-1:0] hi;

  logic             bit_r;
  logic [VAL_W-1:0] diff_r;

  assign idx_ext = {{AW{1'b0}}, idx_r};
  assign addr    = idx_ext[AW-1:0];

  assign stat.action  = act_r;
  assign stat.idx_ok  = ({{(CMPW-IDX_W){1'b0}}, idx_r} < CMPW'(DIM));
  assign stat.mm_done = mm_done;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      act_r <= act_t'(in_action);
      idx_r <= in_index;
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= mm_res;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= mem[addr];
    end
  end

  // operand select for the shared unit; the multiply takes the reduced
  // secret word straight off the unit's result
  always_comb begin
    mm_x = val_r;
    mm_a = VAL_W'(1);
    unique case (cmd.mm_op)
      MM_RED_V:  mm_x = val_r;
      MM_RED_S:  mm_x = mem_q_r;
      MM_MUL: begin
        mm_x = val_r;
        mm_a = mm_res;
      end
      MM_RED_IP: mm_x = ip_r;
      default:   mm_x = val_r;
    endcase
  end

  lbd_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mm_start),
    .x     (mm_x),
    .a     (mm_a),
    .q     (q),
    .done  (mm_done),
    .res   (mm_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.mm_start) begin
      dest_r <= cmd.mm_op;
    end
    if (mm_done) begin
      case (dest_r)
        MM_RED_V:  vred_r  <= mm_res;
        MM_MUL:    prod_r  <= mm_res;
        MM_RED_IP: ipred_r <= mm_res;
        default:   ;
      endcase
    end
  end

  always_comb begin
    ip_sum  = {1'b0, ipred_r} + {1'b0, prod_r};
    ip_nxt  = (ip_sum >= {1'b0, q}) ? VAL_W'(ip_sum - {1'b0, q}) : VAL_W'(ip_sum);
    diff_w  = (vred_r >= ipred_r) ? ({1'b0, vred_r} - {1'b0, ipred_r})
                                  : ({1'b0, vred_r} + {1'b0, q} - {1'b0, ipred_r});
    diff    = VAL_W'(diff_w);
    lo      = q >> 2;
    three_q = {2'b00, q} + {1'b0, q, 1'b0};
    hi      = VAL_W'(three_q >> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r <= '0;
    end else if (cmd.out_load) begin
      ip_r <= '0;
    end else if (cmd.ip_acc) begin
      ip_r <= ip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bit_r  <= (diff > lo) && (diff < hi);
      diff_r <= diff;
    end
  end

  assign out_recovered_bit = bit_r;
  assign out_difference    = diff_r;

endmodule

FILE: src/lbd_ctrl.sv
// ----------------------------------------------------------------------------
// lbd_ctrl
// Sequencer: decodes each request and steps the datapath through the
// reductions and multiply it needs; owns the handshakes.
// ----------------------------------------------------------------------------
module lbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lbd_pkg::dp_cmd_t   cmd,
  input  lbd_pkg::dp_stat_t  stat
);
  import lbd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_FETCH   = 9'b000000100,
    S_WAIT_S  = 9'b000001000,
    S_WAIT_M  = 9'b000010000,
    S_WAIT_V  = 9'b000100000,
    S_WAIT_IP = 9'b001000000,
    S_ACCUM   = 9'b010000000,
    S_DIFF    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mm_op = MM_RED_V;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.action)
          ACT_LOAD: begin
            if (stat.idx_ok) begin
              cmd.mm_start = 1'b1;
              state_nxt    = S_WAIT_V;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          ACT_ELEM: begin
            if (stat.idx_ok) begin
              cmd.mem_rd = 1'b1;
              state_nxt  = S_FETCH;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          ACT_CLOSE: begin
            cmd.mm_start = 1'b1;
            state_nxt    = S_WAIT_V;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FETCH: begin
        cmd.mm_start = 1'b1;
        cmd.mm_op    = MM_RED_S;
        state_nxt    = S_WAIT_S;
      end
      S_WAIT_S: begin
        if (stat.mm_done) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_MUL;
          state_nxt    = S_WAIT_M;
        end
      end
      S_WAIT_M: begin
        if (stat.mm_done) begin
          cmd.mm_start = 1'b1;
          cmd.mm_op    = MM_RED_IP;
          state_nxt    = S_WAIT_IP;
        end
      end
      S_WAIT_V: begin
        if (stat.mm_done) begin
          if (stat.action == ACT_LOAD) begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.mm_start = 1'b1;
            cmd.mm_op    = MM_RED_IP;
            state_nxt    = S_WAIT_IP;
          end
        end
      end
      S_WAIT_IP: begin
        if (stat.mm_done) begin
          state_nxt = (stat.action == ACT_ELEM) ? S_ACCUM : S_DIFF;
        end
      end
      S_ACCUM: begin
        cmd.ip_acc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_DIFF: begin
        // hold until the result register is free
        if (!(out_valid_r && out_stall)) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/lwe_bit_decryption.sv
// ----------------------------------------------------------------------------
// lwe_bit_decryption
// LWE decryption of one message bit per ciphertext column.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_action, in_index, in_value
//   out      output     out_valid/out_stall out_recovered_bit, out_difference
//   cfg      input      APB psel/penable   paddr, pwdata, prdata (modulus)
//
// Every modular step runs as a pass of one shared bit-serial multiplier.
// Secret load: a reduction pass; ciphertext element: three passes;
// closing value: two passes.
// One request at a time; in_stall is high from acceptance to completion.
// A waiting result holds out_* until taken; the next request is accepted
// meanwhile. Synchronous active-low reset; no clearing pass after reset.
// ----------------------------------------------------------------------------
module lwe_bit_decryption #(
  parameter int DIM = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lbd_pkg::ACT_W-1:0]   in_action,
  input  logic [lbd_pkg::IDX_W-1:0]   in_index,
  input  logic [lbd_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_recovered_bit,
  output logic [lbd_pkg::VAL_W-1:0]   out_difference,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lbd_pkg::*;

  logic [VAL_W-1:0] modulus_r;
  logic [VAL_W-1:0] q_eff;
  logic             wr_en;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (wr_en && (paddr[2] == REG_MODULUS)) begin
      modulus_r <= pwdata[VAL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MODULUS) ? {1'b0, modulus_r} : 32'd0;

  // clamp tiny moduli
  assign q_eff = (modulus_r < MOD_MIN) ? MOD_MIN : modulus_r;

  lbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lbd_datapath #(
    .DIM (DIM)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .q                 (q_eff),
    .in_action         (in_action),
    .in_index          (in_index),
    .in_value          (in_value),
    .out_recovered_bit (out_recovered_bit),
    .out_difference    (out_difference)
  );

endmodule

FILE: src/lbd_checker.sv
// ----------------------------------------------------------------------------
// lbd_checker
// Port-level checks on the LWE bit decryption block.
// ----------------------------------------------------------------------------
module lbd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_recovered_bit,
  input logic [lbd_pkg::VAL_W-1:0]   out_difference
);
  import lbd_pkg::*;

  // one request in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous request in flight");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request being processed");

  // zero difference never decodes as a one
  a_zero_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_difference == '0)) |-> !out_recovered_bit)
    else $error("bit set with zero difference");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_difference)
                                  && $stable(out_recovered_bit)))
    else $error("stalled result changed");

endmodule

bind lwe_bit_decryption lbd_checker u_lbd_checker (.*);
